[rtl/core/ist_pkg.sv]
// ---------------------------------------------------------------------------
// Insertion sort trace package
// Shared widths, defaults, operation codes and sequencer states.
// ---------------------------------------------------------------------------
package ist_pkg;

  // Default values for the top-level parameters.
  localparam int MAX_ELEMENTS_DEF = 32;
  localparam int VALUE_WIDTH_DEF  = 16;

  // Fixed widths of the channel fields.
  localparam int IN_VALUE_WIDTH = 16;
  localparam int INDEX_WIDTH    = 5;

  // Operation codes carried in op_kind.
  localparam logic OP_COMPARE = 1'b0;
  localparam logic OP_SWAP    = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_SWAP = 4'b0100,
    S_FILL = 4'b1000
  } state_t;

endpackage

[rtl/core/ist_if.sv]
// ---------------------------------------------------------------------------
// Insertion sort trace channels
// Valid/ready channels for input elements and for trace records.
// ---------------------------------------------------------------------------
interface ist_in_if import ist_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      start_req;
  logic [IN_VALUE_WIDTH-1:0] value;

  modport source (output valid, output start_req, output value, input ready);
  modport sink   (input valid, input start_req, input value, output ready);
endinterface

interface ist_out_if import ist_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   op_kind;
  logic [INDEX_WIDTH-1:0] index_a;
  logic [INDEX_WIDTH-1:0] index_b;
  logic                   last;

  modport source (output valid, output op_kind, output index_a, output index_b,
                  output last, input ready);
  modport sink   (input valid, input op_kind, input index_a, input index_b,
                  input last, output ready);
endinterface

[rtl/core/ist_ram.sv]
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ist_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/insertion_sort_trace_unit.sv]
// ---------------------------------------------------------------------------
// Insertion sort trace unit
// Online insertion sort that emits its compare and swap trace as records.
// ---------------------------------------------------------------------------
// Each element beat on the items channel is inserted into a sorted store, and
// the unit emits the compare and swap operations of a textbook insertion sort
// as records on the records channel, with last set on the final record of the
// element. A beat with start_req set begins a new array. The first element of
// an array produces no record, and elements that arrive once the store holds
// MAX_ELEMENTS entries are dropped silently. The unit takes one element at a
// time: items.ready is low while an insertion is under way. An element walks
// through a compare step and a swap step for each stored entry that it
// shifts, at most MAX_ELEMENTS-1 of them, and stops on a compare with an entry
// that is not greater or, after the swap at position 0, on a fill step. A
// first or dropped element is taken without a walk. The pace is set by the
// single store read port with its registered read and the one shared
// comparator, which alternate between a compare step and a swap step, and a
// walk stalls while the record register is held by a low records.ready.
// ---------------------------------------------------------------------------
module insertion_sort_trace_unit import ist_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ist_in_if.sink     items,
  ist_out_if.source  records
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  // Sequencer and element state.
  state_t                 state;
  logic [CNT_W-1:0]       count;      // elements held; during a walk, the new index i
  logic [IDX_W-1:0]       j;          // stored entry under comparison
  logic [VALUE_WIDTH-1:0] cur;        // element being inserted
  logic [VALUE_WIDTH-1:0] shift_val;  // entry moving up one place

  // Output record register.
  logic                   rec_valid;
  logic                   rec_kind;
  logic [INDEX_WIDTH-1:0] rec_a;
  logic [INDEX_WIDTH-1:0] rec_b;
  logic                   rec_last;

  // Store port signals.
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [IDX_W-1:0]       rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;

  logic                   accept;
  logic                   slot_free;
  logic                   rec_load;
  logic                   greater;
  logic [CNT_W-1:0]       count_eff;
  logic [VALUE_WIDTH-1:0] in_value;

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;

  // The record register can take a new record when it is empty or its
  // current record leaves on this edge.
  assign slot_free = !rec_valid || records.ready;

  // A compare or swap step loads a record whenever the register has room.
  assign rec_load = slot_free && (state == S_CMP || state == S_SWAP);

  // A start request clears the count before the element is looked at.
  assign count_eff = items.start_req ? '0 : count;
  assign in_value  = VALUE_WIDTH'(items.value);

  // The one shared comparator: the stored entry read last cycle against the
  // new element. Equal values do not shift, which keeps the sort stable.
  assign greater = rd_data > cur;

  // Read address. In the compare state the address is held so that the read
  // data stay valid through a stall; the idle and swap states look one step ahead.
  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = IDX_W'(count_eff - CNT_W'(1));
      S_SWAP:  rd_addr = j - IDX_W'(1);
      default: rd_addr = j;
    endcase
  end

  // Write port: the first element, an entry moving up, or the new element
  // dropping into its final place.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j + IDX_W'(1);
    wr_data = cur;
    unique case (state)
      S_IDLE: begin
        if (accept && count_eff == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = in_value;
        end
      end
      S_CMP: begin
        wr_en = slot_free && !greater;
      end
      S_SWAP: begin
        wr_en   = slot_free;
        wr_data = shift_val;
      end
      S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  ist_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer. A compare step emits compare (j, i); if the stored entry is
  // greater, the swap step emits swap (j, j+1), moves the entry up and steps
  // j down. The walk ends on the first entry that is not greater, or after
  // the swap at position 0, where the fill step places the new element.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      j         <= '0;
      rec_valid <= 1'b0;
    end else begin
      if (rec_load) begin
        rec_valid <= 1'b1;
      end else if (records.ready) begin
        rec_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (count_eff >= CNT_W'(MAX_ELEMENTS)) begin
              count <= count_eff;
            end else if (count_eff == '0) begin
              count <= CNT_W'(1);
            end else begin
              count <= count_eff;
              j     <= IDX_W'(count_eff - CNT_W'(1));
              state <= S_CMP;
            end
          end
        end

        S_CMP: begin
          if (slot_free) begin
            if (greater) begin
              state <= S_SWAP;
            end else begin
              count <= count + CNT_W'(1);
              state <= S_IDLE;
            end
          end
        end

        S_SWAP: begin
          if (slot_free) begin
            if (j == '0) begin
              state <= S_FILL;
            end else begin
              j     <= j - IDX_W'(1);
              state <= S_CMP;
            end
          end
        end

        S_FILL: begin
          count <= count + CNT_W'(1);
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Element and record payload registers; these need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= in_value;
    end
    if (state == S_CMP && slot_free) begin
      shift_val <= rd_data;
      rec_kind  <= OP_COMPARE;
      rec_a     <= INDEX_WIDTH'(j);
      rec_b     <= INDEX_WIDTH'(count);
      rec_last  <= !greater;
    end else if (state == S_SWAP && slot_free) begin
      rec_kind  <= OP_SWAP;
      rec_a     <= INDEX_WIDTH'(j);
      rec_b     <= INDEX_WIDTH'(j) + INDEX_WIDTH'(1);
      rec_last  <= (j == '0);
    end
  end

  assign records.valid   = rec_valid;
  assign records.op_kind = rec_kind;
  assign records.index_a = rec_a;
  assign records.index_b = rec_b;
  assign records.last    = rec_last;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Insertion sort trace unit testbench
// Feeds element beats into the unit and checks every compare and swap record
// it emits against a cycle-free model of the same online insertion sort.
// ---------------------------------------------------------------------------
module tb_top;
  import ist_pkg::*;

  // One element beat as the driver presents it.
  typedef struct {
    logic                      start_req;
    logic [IN_VALUE_WIDTH-1:0] value;
  } element_beat_t;

  // One trace record as the unit emits it.
  typedef struct {
    logic                   op_kind;
    logic [INDEX_WIDTH-1:0] index_a;
    logic [INDEX_WIDTH-1:0] index_b;
    logic                   last;
  } trace_rec_t;

  localparam int STORE_LIMIT    = MAX_ELEMENTS_DEF;
  localparam int TARGET_ITEMS   = 370;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int MAX_REPORTS    = 10;

  logic clk;
  logic rst;

  ist_in_if  items_if ();
  ist_out_if records_if ();

  insertion_sort_trace_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .records (records_if)
  );

  // Element beats waiting for the driver, and the records the unit still owes.
  element_beat_t element_queue[$];
  trace_rec_t    expected_trace[$];

  // Private copy of the sorted store and the element count, advanced once per
  // accepted element beat.
  logic [IN_VALUE_WIDTH-1:0] sorted_copy [STORE_LIMIT];
  int                        copy_count;

  // Planning copy of the element count, used only while the stimulus is built
  // so that dropped beats do not count toward the item target.
  int plan_count;
  int planned_items;

  int  trace_errors;
  int  beats_taken;
  int  beats_dropped;
  int  arrays_started;
  int  records_seen;
  int  swaps_seen;
  int  deepest_insert;
  int  idle_cycles;
  int  in_gap;
  int  out_hold;
  bit  item_pending;
  bit  item_beat;

  // The clock toggles every nanosecond for a 2 ns period.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Queue one element beat and track whether the unit will actually store it.
  function automatic void queue_element(input logic start, input logic [15:0] val);
    element_beat_t b;
    b.start_req = start;
    b.value     = val;
    element_queue.insert(element_queue.size(), b);
    if (start) plan_count = 0;
    if (plan_count < STORE_LIMIT) begin
      plan_count++;
      planned_items++;
    end
  endfunction

  function automatic void push_record(input logic kind, input int a, input int b);
    trace_rec_t r;
    r.op_kind = kind;
    r.index_a = a[INDEX_WIDTH-1:0];
    r.index_b = b[INDEX_WIDTH-1:0];
    r.last    = 1'b0;
    expected_trace.insert(expected_trace.size(), r);
  endfunction

  // Inserts one accepted element into the private store and appends the
  // compare and swap records that the insertion walk produces. The new element
  // starts at position i; each stored entry strictly greater than it moves up
  // one place, so equal values keep their arrival order.
  function automatic void insert_element(input logic start, input logic [15:0] val);
    int         i;
    int         j;
    int         shifts;
    trace_rec_t tail;
    beats_taken++;
    if (start) begin
      copy_count = 0;
      arrays_started++;
    end
    // A full store drops the beat without a record.
    if (copy_count >= STORE_LIMIT) begin
      beats_dropped++;
      return;
    end
    i = copy_count;
    // The first element of an array lands at position 0 silently.
    if (i == 0) begin
      sorted_copy[0] = val;
      copy_count = 1;
      return;
    end
    j = i - 1;
    shifts = 0;
    push_record(OP_COMPARE, j, i);
    while (j >= 0 && sorted_copy[j] > val) begin
      push_record(OP_SWAP, j, j + 1);
      sorted_copy[j + 1] = sorted_copy[j];
      shifts++;
      j--;
      if (j >= 0) push_record(OP_COMPARE, j, i);
    end
    sorted_copy[j + 1] = val;
    copy_count++;
    if (shifts > deepest_insert) deepest_insert = shifts;
    // The final record of this element carries last.
    tail = expected_trace.pop_back();
    tail.last = 1'b1;
    expected_trace.insert(expected_trace.size(), tail);
  endfunction

  // Compares one record from the unit against the oldest expectation.
  function automatic void check_record(input trace_rec_t got);
    trace_rec_t exp_rec;
    records_seen++;
    if (got.op_kind === OP_SWAP) swaps_seen++;
    if (expected_trace.size() == 0) begin
      if (trace_errors < MAX_REPORTS)
        $display("[%0t] record with nothing outstanding: kind=%0b a=%0d b=%0d last=%0b",
                 $realtime, got.op_kind, got.index_a, got.index_b, got.last);
      trace_errors++;
      return;
    end
    exp_rec = expected_trace.pop_front();
    if (got.op_kind !== exp_rec.op_kind || got.index_a !== exp_rec.index_a ||
        got.index_b !== exp_rec.index_b || got.last !== exp_rec.last) begin
      if (trace_errors < MAX_REPORTS) begin
        $display("[%0t] record mismatch: expected kind=%0b a=%0d b=%0d last=%0b,",
                 $realtime, exp_rec.op_kind, exp_rec.index_a, exp_rec.index_b,
                 exp_rec.last);
        $display("    got kind=%0b a=%0d b=%0d last=%0b",
                 got.op_kind, got.index_a, got.index_b, got.last);
      end
      trace_errors++;
    end
  endfunction

  // Builds one array of the given length. The shape of the values decides how
  // deep the insertion walks go: descending arrays give the longest traces, a
  // narrow value range gives many equal values, ascending ones give no swaps.
  function automatic void queue_array(input int len);
    int          shape;
    int          k;
    int          cur;
    logic [15:0] v;
    shape = $urandom_range(0, 4);
    cur = (shape == 2) ? 65535 - $urandom_range(0, 1000) : $urandom_range(0, 1000);
    for (k = 0; k < len; k++) begin
      case (shape)
        0: v = 16'($urandom_range(0, 65535));
        1: v = 16'($urandom_range(0, 7));
        2: begin
          v = cur[15:0];
          cur = cur - $urandom_range(0, 1800);
          if (cur < 0) cur = 0;
        end
        3: begin
          v = cur[15:0];
          cur = cur + $urandom_range(0, 1800);
          if (cur > 65535) cur = 65535;
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            default: v = 16'($urandom_range(0, 65535));
          endcase
        end
      endcase
      queue_element(k == 0, v);
    end
  endfunction

  // Stimulus and end of run.
  initial begin
    int r;
    int len;
    items_if.valid     = 1'b0;
    items_if.start_req = 1'b0;
    items_if.value     = '0;
    records_if.ready   = 1'b0;
    rst                = 1'b1;
    copy_count = 0; plan_count = 0; planned_items = 0;
    trace_errors = 0; beats_taken = 0; beats_dropped = 0; arrays_started = 0;
    records_seen = 0; swaps_seen = 0; deepest_insert = 0; idle_cycles = 0;
    in_gap = 0; out_hold = 0; item_pending = 1'b0; item_beat = 1'b0;

    // Directed part. The very first beat has no start flag, which relies on
    // the count being cleared by reset. Then a larger value that shifts
    // nothing, the smallest value that walks all the way to position 0, a
    // repeat of a stored value to show stability, and three restarts,
    // one of them an array of a single element.
    queue_element(1'b0, 16'h1234);
    queue_element(1'b0, 16'hFFFF);
    queue_element(1'b0, 16'h0000);
    queue_element(1'b0, 16'h1234);
    queue_element(1'b0, 16'h8000);
    queue_element(1'b0, 16'h0000);
    queue_element(1'b1, 16'h0000);
    queue_element(1'b0, 16'h0000);
    queue_element(1'b0, 16'hFFFF);
    queue_element(1'b0, 16'h5555);
    queue_element(1'b0, 16'hAAAA);
    queue_element(1'b0, 16'h0001);
    queue_element(1'b1, 16'h0001);
    queue_element(1'b1, 16'h0002);
    queue_element(1'b0, 16'h0001);
    queue_element(1'b0, 16'h0002);

    // A full store right away: an array of random shape past the capacity, so
    // the trailing beats are dropped.
    queue_array(STORE_LIMIT + 3);

    // Random part: mostly well-formed arrays with random content, a few long
    // enough to fill the store, and some single noise beats with a random
    // start flag that cut arrays short or extend them.
    while (planned_items < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_element(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 72)      len = $urandom_range(2, 10);
        else if (r < 90) len = $urandom_range(11, STORE_LIMIT - 1);
        else             len = $urandom_range(STORE_LIMIT, STORE_LIMIT + 3);
        queue_array(len);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for every beat to be taken and every record to come back.
    while (element_queue.size() != 0 || item_pending || expected_trace.size() != 0)
      @(posedge clk);
    // Let a possible stray record show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d element beats in %0d arrays, %0d of them dropped on a full store.",
             beats_taken, arrays_started, beats_dropped);
    $display("Checked %0d trace records, %0d swaps, deepest insertion %0d shifts, %0d errors.",
             records_seen, swaps_seen, deepest_insert, trace_errors);
    if (trace_errors == 0 && expected_trace.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Monitor: samples both channels at the rising edge. A beat on the items
  // channel advances the private sort; a beat on the records channel is
  // checked. The watchdog counts edges with no beat on either channel.
  always @(posedge clk) begin
    trace_rec_t got;
    item_beat = 1'b0;
    if (!rst) begin
      if (items_if.valid && items_if.ready) begin
        item_beat = 1'b1;
        insert_element(items_if.start_req, items_if.value);
      end
      if (records_if.valid && records_if.ready) begin
        got.op_kind = records_if.op_kind;
        got.index_a = records_if.index_a;
        got.index_b = records_if.index_b;
        got.last    = records_if.last;
        check_record(got);
      end
      if (item_beat || (records_if.valid && records_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("[%0t] watchdog: no beat for %0d cycles, %0d records outstanding",
                   $realtime, idle_cycles, expected_trace.size());
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Driver for the items channel, working on the falling edge. A beat stays
  // up until the monitor has seen it taken; then a random gap may follow.
  // Every third stretch of 48 beats runs with no gaps at all.
  always @(negedge clk) begin
    element_beat_t nxt;
    if (rst) begin
      items_if.valid <= 1'b0;
    end else begin
      if (item_pending && item_beat) item_pending = 1'b0;
      if (!item_pending) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (element_queue.size() != 0) begin
          nxt = element_queue.pop_front();
          items_if.start_req <= nxt.start_req;
          items_if.value     <= nxt.value;
          item_pending = 1'b1;
          in_gap = ((beats_taken / 48) % 3 == 2) ? 0 : pick_gap();
        end
      end
      items_if.valid <= item_pending;
    end
  end

  // Backpressure on the records channel, independent of valid so that stalls
  // land on every step of the insertion walk. Every fourth stretch of 64
  // records runs with ready held high.
  always @(negedge clk) begin
    if (rst) begin
      records_if.ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      records_if.ready <= 1'b0;
    end else begin
      records_if.ready <= 1'b1;
      if ((records_seen / 64) % 4 != 3 && $urandom_range(0, 99) < 25)
        out_hold = pick_gap();
    end
  end

endmodule
